// ----- hw/rtl/speed_slew_limiter_with_mode_hysteresis_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the speed slew limiter
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPEED_SLEW_LIMITER_WITH_MODE_HYSTERESIS_CORE_DEFINES_SVH
`define SPEED_SLEW_LIMITER_WITH_MODE_HYSTERESIS_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SSLH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSLH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SSLH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SSLH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/sslh_pkg.sv -----
// ----------------------------------------------------------------------------
// sslh_pkg
// Types and constants shared by the speed slew limiter files.
// ----------------------------------------------------------------------------
package sslh_pkg;

    localparam int SPEED_W = 24;
    localparam int STEP_W  = 24;
    localparam int THR_W   = 23;
    localparam int DRIVE_W = 16;
    localparam int MS_W    = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [STEP_W-1:0] MAX_STEP_RST = 24'd1678;
    localparam logic [THR_W-1:0]  HIGH_THR_RST = 23'd458752;
    localparam logic [THR_W-1:0]  LOW_THR_RST  = 23'd262144;
    localparam logic [THR_W-1:0]  LIMIT_RST    = 23'd1310720;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_STEP = 2'd0,
        REG_HIGH_THR = 2'd1,
        REG_LOW_THR  = 2'd2,
        REG_LIMIT    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0] max_step_per_ms;
        logic [THR_W-1:0]  high_threshold;
        logic [THR_W-1:0]  low_threshold;
        logic [THR_W-1:0]  speed_cap;
    } cfg_t;

    typedef struct packed {
        logic                      cmd;
        logic                      enable_in;
        logic signed [SPEED_W-1:0] speed_req;
        logic [DRIVE_W-1:0]        drive_value;
        logic [MS_W-1:0]           elapsed_ms;
    } item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic signed [SPEED_W-1:0] target;
        logic                      hall;
        logic                      enable;
        logic [DRIVE_W-1:0]        drive;
    } state_t;

endpackage

// ----- hw/rtl/sslh_in_if.sv -----
// ----------------------------------------------------------------------------
// sslh_in_if
// Input item channel: valid/ready with set and tick fields.
// ----------------------------------------------------------------------------
interface sslh_in_if import sslh_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic                      enable_in;
    logic signed [SPEED_W-1:0] speed_req;
    logic [DRIVE_W-1:0]        drive_value;
    logic [MS_W-1:0]           elapsed_ms;

    modport source (
        output valid, cmd, enable_in, speed_req, drive_value, elapsed_ms,
        input  ready
    );

    modport sink (
        input  valid, cmd, enable_in, speed_req, drive_value, elapsed_ms,
        output ready
    );

endinterface

// ----- hw/rtl/sslh_out_if.sv -----
// ----------------------------------------------------------------------------
// sslh_out_if
// Result channel: valid/ready with speed, mode, enable and drive.
// ----------------------------------------------------------------------------
interface sslh_out_if import sslh_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] ramped_speed;
    logic                      hall_mode;
    logic                      enable_out;
    logic [DRIVE_W-1:0]        drive_out;

    modport source (
        output valid, ramped_speed, hall_mode, enable_out, drive_out,
        input  ready
    );

    modport sink (
        input  valid, ramped_speed, hall_mode, enable_out, drive_out,
        output ready
    );

endinterface

// ----- hw/rtl/sslh_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sslh_cfg_regs
// Configuration register file; each of the four indexes selects one register.
// ----------------------------------------------------------------------------
module sslh_cfg_regs import sslh_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MAX_STEP: cfg_next.max_step_per_ms = cfg_data[STEP_W-1:0];
                REG_HIGH_THR: cfg_next.high_threshold  = cfg_data[THR_W-1:0];
                REG_LOW_THR:  cfg_next.low_threshold   = cfg_data[THR_W-1:0];
                REG_LIMIT:    cfg_next.speed_cap       = cfg_data[THR_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_step_per_ms <= MAX_STEP_RST;
            cfg_reg.high_threshold  <= HIGH_THR_RST;
            cfg_reg.low_threshold   <= LOW_THR_RST;
            cfg_reg.speed_cap       <= LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/sslh_ramp_calc.sv -----
// ----------------------------------------------------------------------------
// sslh_ramp_calc
// Next-state logic: target clamp, slew step and mode hysteresis.
// ----------------------------------------------------------------------------
module sslh_ramp_calc import sslh_pkg::*; (
    input  item_t  item,
    input  state_t cur,
    input  cfg_t   cfg,
    output state_t nxt
);

    logic [SPEED_W-1:0]        tgt_mag;
    logic signed [SPEED_W-1:0] lim_pos;
    logic signed [SPEED_W-1:0] tgt_clamped;
    logic [STEP_W+MS_W-1:0]    step;
    logic [STEP_W+MS_W:0]      step_rnd;
    logic signed [SPEED_W:0]   delta;
    logic [SPEED_W:0]          delta_mag;
    logic [STEP_W+MS_W-1:0]    delta_scaled;
    logic [SPEED_W-1:0]        move;
    logic signed [SPEED_W-1:0] speed_new;
    logic [SPEED_W-1:0]        speed_mag;
    logic                      at_high;
    logic                      at_low;

    // set path
    always_comb
    begin
        lim_pos = SPEED_W'(cfg.speed_cap);
        tgt_mag = item.speed_req[SPEED_W-1] ? SPEED_W'(-item.speed_req)
                                            : SPEED_W'(item.speed_req);
        if (tgt_mag > SPEED_W'(cfg.speed_cap))
            tgt_clamped = item.speed_req[SPEED_W-1] ? -lim_pos : lim_pos;
        else
            tgt_clamped = item.speed_req;
    end

    // tick path
    always_comb
    begin
        step         = cfg.max_step_per_ms * item.elapsed_ms;
        step_rnd     = (STEP_W+MS_W+1)'(step) + (STEP_W+MS_W+1)'(128);
        move         = step_rnd[SPEED_W+7:8];
        delta        = (SPEED_W+1)'(cur.target) - (SPEED_W+1)'(cur.speed);
        delta_mag    = delta[SPEED_W] ? (SPEED_W+1)'(-delta) : (SPEED_W+1)'(delta);
        delta_scaled = (STEP_W+MS_W)'({delta_mag, 8'b0});
        if (delta_scaled < step)
            speed_new = cur.target;
        else if (!delta[SPEED_W] && (delta != '0))
            speed_new = cur.speed + $signed(move);
        else
            speed_new = cur.speed - $signed(move);
        speed_mag = speed_new[SPEED_W-1] ? SPEED_W'(-speed_new) : SPEED_W'(speed_new);
        at_high   = speed_mag >= SPEED_W'(cfg.high_threshold);
        at_low    = speed_mag <= SPEED_W'(cfg.low_threshold);
    end

    always_comb
    begin
        nxt = cur;
        if (item.cmd == CMD_SET)
        begin
            nxt.enable = item.enable_in;
            nxt.drive  = item.drive_value;
            nxt.target = tgt_clamped;
        end
        else if (item.elapsed_ms != '0)
        begin
            nxt.speed = speed_new;
            nxt.hall  = (cur.hall || at_high) && !at_low;
        end
    end

endmodule

// ----- hw/rtl/speed_slew_limiter_with_mode_hysteresis_core.sv -----
// ----------------------------------------------------------------------------
// speed_slew_limiter_with_mode_hysteresis_core
// Slew-rate limited speed setpoint with hall / field oriented mode selection.
// ----------------------------------------------------------------------------
// One item is taken per cycle unless result back-pressure stalls it, and each
// yields one result on the result port, through an input register, then a
// single pass through the clamp, the 24x16 step multiply, the distance compare
// and the speed add that feeds back into the speed register, then the result
// register. That multiply-compare-add loop on the speed register sets the clock
// period. Configuration writes are to be made only while the block is idle.
`include "speed_slew_limiter_with_mode_hysteresis_core_defines.svh"

module speed_slew_limiter_with_mode_hysteresis_core import sslh_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sslh_in_if.sink              item,
    sslh_out_if.source           result
);

    cfg_t   cfg;
    item_t  s1_reg;
    logic   s1_valid_reg;
    state_t state_reg;
    state_t state_next;
    state_t out_reg;
    logic   out_valid_reg;
    logic   advance;
    logic   take;

    sslh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sslh_ramp_calc u_calc (
        .item (s1_reg),
        .cur  (state_reg),
        .cfg  (cfg),
        .nxt  (state_next)
    );

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign take       = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg.cmd         <= item.cmd;
            s1_reg.enable_in   <= item.enable_in;
            s1_reg.speed_req   <= item.speed_req;
            s1_reg.drive_value <= item.drive_value;
            s1_reg.elapsed_ms  <= item.elapsed_ms;
        end
        if (advance)
            out_reg <= state_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.ramped_speed = out_reg.speed;
    assign result.hall_mode    = out_reg.hall;
    assign result.enable_out   = out_reg.enable;
    assign result.drive_out    = out_reg.drive;

    `SSLH_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_reg), "held item changed while stalled")
    `SSLH_ASSERT_NEXT(a_set_keeps_speed, clk, rst_n, advance && (s1_reg.cmd == CMD_SET),
        $stable(state_reg.speed) && $stable(state_reg.hall), "set item altered speed or mode")
    `SSLH_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid_reg, item.ready,
        "input stalled with empty result register")

endmodule

// ----- tb/sv/speed_slew_limiter_with_mode_hysteresis_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed slew limiter testbench
// Sends set and tick commands with random gaps and random result stalls.
// A built-in model of the ramp, target clamp and hall / field oriented mode
// hysteresis predicts every result; the results are compared field by field
// in order. Directed cases come first, then random traffic in several
// configuration phases.
// ----------------------------------------------------------------------------
module speed_slew_limiter_with_mode_hysteresis_core_tb;
    import sslh_pkg::*;

    localparam int SPEED_ONE = 65536;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      hall;
        logic                      enable;
        logic [DRIVE_W-1:0]        drive;
    } speed_report_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sslh_in_if  item_ch ();
    sslh_out_if result_ch ();

    speed_slew_limiter_with_mode_hysteresis_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch.sink),
        .result    (result_ch.source)
    );

    cfg_t          live_cfg;
    state_t        ramp_state;
    speed_report_t speed_reports_due[$];
    int            failures;
    bit            send_quiet;
    bit            recv_quiet;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic speed_report_t next_speed_report(item_t it);
        longint        req;
        longint        lim;
        longint        travel;
        longint        budget;
        longint        move;
        longint        mag_now;
        speed_report_t rep;
        if (it.cmd == CMD_SET)
        begin
            req = longint'($signed(it.speed_req));
            lim = longint'(live_cfg.speed_cap);
            if (req > lim)
                req = lim;
            else if (req < -lim)
                req = -lim;
            ramp_state.target = req[SPEED_W-1:0];
            ramp_state.enable = it.enable_in;
            ramp_state.drive  = it.drive_value;
        end
        else if (it.elapsed_ms != '0)
        begin
            budget = longint'(live_cfg.max_step_per_ms) * longint'(it.elapsed_ms);
            travel = longint'($signed(ramp_state.target)) - longint'($signed(ramp_state.speed));
            if ((travel < 0 ? -travel : travel) * 256 < budget)
                ramp_state.speed = ramp_state.target;
            else
            begin
                move = (budget + 128) >>> 8;
                if (travel > 0)
                    ramp_state.speed = ramp_state.speed + move[SPEED_W-1:0];
                else
                    ramp_state.speed = ramp_state.speed - move[SPEED_W-1:0];
            end
            mag_now = longint'($signed(ramp_state.speed));
            if (mag_now < 0)
                mag_now = -mag_now;
            if (mag_now >= longint'(live_cfg.high_threshold) && !ramp_state.hall)
                ramp_state.hall = 1'b1;
            if (mag_now <= longint'(live_cfg.low_threshold) && ramp_state.hall)
                ramp_state.hall = 1'b0;
        end
        rep.speed  = ramp_state.speed;
        rep.hall   = ramp_state.hall;
        rep.enable = ramp_state.enable;
        rep.drive  = ramp_state.drive;
        return rep;
    endfunction

    function automatic item_t set_cmd(logic en, logic [SPEED_W-1:0] target,
                                      logic [DRIVE_W-1:0] drive);
        item_t it;
        it.cmd         = CMD_SET;
        it.enable_in   = en;
        it.speed_req   = target;
        it.drive_value = drive;
        it.elapsed_ms  = MS_W'($urandom);
        return it;
    endfunction

    function automatic item_t tick_cmd(logic [MS_W-1:0] ms);
        item_t it;
        it.cmd         = CMD_TICK;
        it.enable_in   = 1'($urandom);
        it.speed_req   = SPEED_W'($urandom);
        it.drive_value = DRIVE_W'($urandom);
        it.elapsed_ms  = ms;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= it.cmd;
        item_ch.enable_in   <= it.enable_in;
        item_ch.speed_req   <= it.speed_req;
        item_ch.drive_value <= it.drive_value;
        item_ch.elapsed_ms  <= it.elapsed_ms;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        speed_reports_due.push_back(next_speed_report(it));
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (speed_reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_limits(input logic [STEP_W-1:0] step, input logic [THR_W-1:0] hi,
                                  input logic [THR_W-1:0] lo, input logic [THR_W-1:0] lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_index <= REG_HIGH_THR;
        cfg_data  <= CFG_W'(hi);
        @(posedge clk);
        cfg_index <= REG_LOW_THR;
        cfg_data  <= CFG_W'(lo);
        @(posedge clk);
        cfg_index <= REG_LIMIT;
        cfg_data  <= CFG_W'(lim);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        live_cfg.max_step_per_ms = step;
        live_cfg.high_threshold  = hi;
        live_cfg.low_threshold   = lo;
        live_cfg.speed_cap       = lim;
    endtask

    // reset config: zero tick, full ramp to 20.0 through hall entry, most negative target
    task automatic test_reset_values();
        send_item(tick_cmd(16'd0));
        send_item(set_cmd(1'b1, SPEED_W'(20 * SPEED_ONE), 16'hFFFF));
        repeat (4) send_item(tick_cmd(16'hFFFF));
        send_item(set_cmd(1'b0, 24'h800000, 16'h0000));
        send_item(tick_cmd(16'd0));
    endtask

    task automatic test_step_extremes();
        drain();
        program_limits(24'hFFFFFF, THR_W'(7 * SPEED_ONE), THR_W'(4 * SPEED_ONE), 23'h7FFFFF);
        send_item(set_cmd(1'b1, 24'h7FFFFF, 16'h5A5A));
        send_item(tick_cmd(16'd1));
        send_item(tick_cmd(16'hFFFF));
        send_item(set_cmd(1'b0, 24'h800000, 16'hA5A5));
        send_item(tick_cmd(16'hFFFF));
        drain();
        program_limits(24'd0, THR_W'(7 * SPEED_ONE), THR_W'(4 * SPEED_ONE),
                       THR_W'(20 * SPEED_ONE));
        send_item(set_cmd(1'b1, 24'd0, 16'h00FF));
        send_item(tick_cmd(16'hFFFF));
    endtask

    task automatic test_clamp_extremes();
        drain();
        program_limits(24'h100000, 23'd0, 23'd0, 23'd0);
        send_item(set_cmd(1'b1, 24'h7FFFFF, 16'h1234));
        send_item(tick_cmd(16'd3));
        send_item(set_cmd(1'b0, 24'h800000, 16'hFEDC));
        send_item(tick_cmd(16'd3));
    endtask

    task automatic test_overlapping_thresholds();
        drain();
        program_limits(24'h400000, THR_W'(2 * SPEED_ONE), 23'h7FFFFF, THR_W'(10 * SPEED_ONE));
        send_item(set_cmd(1'b1, SPEED_W'(10 * SPEED_ONE), 16'h8001));
        send_item(tick_cmd(16'd8));
        send_item(tick_cmd(16'hFFFF));
        drain();
        program_limits(24'h400000, THR_W'(3 * SPEED_ONE), THR_W'(3 * SPEED_ONE),
                       THR_W'(10 * SPEED_ONE));
        send_item(set_cmd(1'b1, SPEED_W'(-10 * SPEED_ONE), 16'h7FFE));
        send_item(tick_cmd(16'd28));
        send_item(tick_cmd(16'd4));
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [STEP_W-1:0] step;
        logic [THR_W-1:0]  hi;
        logic [THR_W-1:0]  lo;
        logic [THR_W-1:0]  lim;
        int                span;
        int                t;
        int                pick;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(0, 7))
                0:       step = '0;
                1:       step = 24'hFFFFFF;
                default: step = STEP_W'($urandom_range(1 << 14, 1 << 22));
            endcase
            hi = THR_W'($urandom_range(SPEED_ONE, 12 * SPEED_ONE));
            case ($urandom_range(0, 5))
                0:       lo = THR_W'($urandom_range(hi, hi + 2 * SPEED_ONE));
                1:
                begin
                    hi = 23'h7FFFFF;
                    lo = '0;
                end
                default: lo = THR_W'($urandom_range(0, hi));
            endcase
            case ($urandom_range(0, 5))
                0:       lim = 23'h7FFFFF;
                1:       lim = THR_W'($urandom);
                default: lim = THR_W'($urandom_range(2 * SPEED_ONE, 40 * SPEED_ONE));
            endcase
            drain();
            program_limits(step, hi, lo, lim);
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            span = int'(lim) + int'(lim) / 2 + 1;
            if (span > 8388607)
                span = 8388607;
            for (int n = 0; n < per_phase; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    if ($urandom_range(0, 9) < 3)
                        t = int'($urandom);
                    else
                        t = int'($urandom_range(0, 2 * span)) - span;
                    send_item(set_cmd(1'($urandom), SPEED_W'(t), DRIVE_W'($urandom)));
                end
                else if (pick < 42)
                    send_item(tick_cmd(16'd0));
                else if (pick < 85)
                    send_item(tick_cmd(MS_W'($urandom_range(1, 16))));
                else
                    send_item(tick_cmd(MS_W'($urandom)));
            end
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
    endtask

    initial
    begin
        int            gap;
        speed_report_t want;
        forever
        begin
            gap = recv_quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            if (speed_reports_due.size() == 0)
            begin
                $display("%0t ns: unexpected result transfer, expected none, got speed %0d",
                         $time, result_ch.ramped_speed);
                failures++;
            end
            else
            begin
                want = speed_reports_due.pop_front();
                if (result_ch.ramped_speed !== want.speed)
                begin
                    $display("%0t ns: ramped_speed mismatch, expected %0d, got %0d",
                             $time, want.speed, result_ch.ramped_speed);
                    failures++;
                end
                if (result_ch.hall_mode !== want.hall)
                begin
                    $display("%0t ns: hall_mode mismatch, expected %0b, got %0b",
                             $time, want.hall, result_ch.hall_mode);
                    failures++;
                end
                if (result_ch.enable_out !== want.enable)
                begin
                    $display("%0t ns: enable_out mismatch, expected %0b, got %0b",
                             $time, want.enable, result_ch.enable_out);
                    failures++;
                end
                if (result_ch.drive_out !== want.drive)
                begin
                    $display("%0t ns: drive_out mismatch, expected %0h, got %0h",
                             $time, want.drive, result_ch.drive_out);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= REG_MAX_STEP;
        cfg_data            <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.cmd         <= CMD_SET;
        item_ch.enable_in   <= 1'b0;
        item_ch.speed_req   <= '0;
        item_ch.drive_value <= '0;
        item_ch.elapsed_ms  <= '0;
        live_cfg.max_step_per_ms = MAX_STEP_RST;
        live_cfg.high_threshold  = HIGH_THR_RST;
        live_cfg.low_threshold   = LOW_THR_RST;
        live_cfg.speed_cap       = LIMIT_RST;
        ramp_state = '0;
        failures   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_step_extremes();
        test_clamp_extremes();
        test_overlapping_thresholds();
        test_random_traffic(12, 128);

        drain();
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
